/* hw/rtl/bsc_pkg.sv */
// shared types and constants for the banker's safety check unit
package bsc_pkg;

	localparam int FIELD_W = 16;
	localparam int NRES    = 3;
	localparam int IDX_W   = 5;
	localparam int STAT_W  = 2;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNSAFE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

	localparam logic [1:0] REG_TOTAL_A = 2'd0;
	localparam logic [1:0] REG_TOTAL_B = 2'd1;
	localparam logic [1:0] REG_TOTAL_C = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PREP  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_EVAL  = 4'b1000
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic grant;
		logic clr;
	} lane_ctl_t;

endpackage

/* hw/rtl/bsc_lane.sv */
// one check lane: bank of process records, done bits and need-fits compare
module bsc_lane #(
	parameter int LANE_ID   = 0,
	parameter int LANES     = 4,
	parameter int MAX_PROCS = 32,
	parameter int RES_WIDTH = 16,
	localparam int ROWS     = (MAX_PROCS + LANES - 1) / LANES,
	localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int CW       = $clog2(MAX_PROCS + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bsc_pkg::lane_ctl_t                    ctl,
	input  logic [RAW-1:0]                        wr_row,
	input  logic [bsc_pkg::NRES*RES_WIDTH-1:0]    wr_alloc,
	input  logic [bsc_pkg::NRES*RES_WIDTH-1:0]    wr_need,
	input  logic [RAW-1:0]                        rd_row,
	input  logic [CW-1:0]                         proc_cnt,
	input  logic [bsc_pkg::NRES*RES_WIDTH-1:0]    avail,
	output logic                                  cand,
	output logic [bsc_pkg::NRES*RES_WIDTH-1:0]    alloc
);

	localparam int RW   = RES_WIDTH;
	localparam int XW   = $clog2(ROWS * LANES + 1);
	localparam int VW   = bsc_pkg::NRES * RW;

	logic [VW-1:0]   alloc_mem_q [ROWS];
	logic [VW-1:0]   need_mem_q  [ROWS];
	logic [VW-1:0]   alloc_s1;
	logic [VW-1:0]   need_s1;
	logic [ROWS-1:0] done_q;
	logic            in_set;
	logic            fits;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			alloc_mem_q[wr_row] <= wr_alloc;
			need_mem_q[wr_row]  <= wr_need;
		end
		alloc_s1 <= alloc_mem_q[rd_row];
		need_s1  <= need_mem_q[rd_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (ctl.clr) begin
			done_q <= '0;
		end else if (ctl.grant) begin
			done_q[rd_row] <= 1'b1;
		end
	end

	assign in_set = (XW'(rd_row) * XW'(LANES) + XW'(LANE_ID)) < XW'(proc_cnt);

	always_comb begin
		fits = 1'b1;
		for (int r = 0; r < bsc_pkg::NRES; r++) begin
			if (need_s1[r*RW +: RW] > avail[r*RW +: RW]) begin
				fits = 1'b0;
			end
		end
	end

	assign cand  = fits && in_set && !done_q[rd_row];
	assign alloc = alloc_s1;

endmodule

/* hw/rtl/bsc_pick.sv */
// merge stage: first candidate lane at or after the row offset wins
module bsc_pick #(
	parameter int LANES     = 4,
	parameter int RES_WIDTH = 16,
	localparam int SLW      = (LANES > 1) ? $clog2(LANES) : 1,
	localparam int OW       = $clog2(LANES + 1)
) (
	input  logic [LANES-1:0]                             cand,
	input  logic [OW-1:0]                                off,
	input  logic [LANES*bsc_pkg::NRES*RES_WIDTH-1:0]     alloc_all,
	output logic                                         hit,
	output logic [SLW-1:0]                               sel,
	output logic [bsc_pkg::NRES*RES_WIDTH-1:0]           sel_alloc
);

	localparam int VW  = bsc_pkg::NRES * RES_WIDTH;

	always_comb begin
		hit       = 1'b0;
		sel       = '0;
		sel_alloc = alloc_all[0 +: VW];
		for (int l = LANES - 1; l >= 0; l--) begin
			if (cand[l] && (OW'(l) >= off)) begin
				hit       = 1'b1;
				sel       = SLW'(l);
				sel_alloc = alloc_all[l*VW +: VW];
			end
		end
	end

endmodule

/* hw/rtl/bankers_safety_check_unit.sv */
// banker's safety check unit: process record load, lane-parallel grant passes
// process records load one per accepted start while idle; a check runs a prep state,
// then per row a fetch and an eval state and an eval per grant; LANES processes a row
// results leave in the cycle after their decision, one per cycle at most; busy drops start
// throughput set by the single shared avail vector: one grant per cycle, fetch stalls it
// reset clears the totals, the process set and all done bits at once; no clearing pass
module bankers_safety_check_unit #(
	parameter int MAX_PROCS = 32,
	parameter int RES_WIDTH = 16,
	parameter int LANES     = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bsc_pkg::ADDR_W-1:0]         paddr,
	input  logic [bsc_pkg::DATA_W-1:0]         pwdata,
	output logic [bsc_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic [bsc_pkg::FIELD_W-1:0]        alloc_a,
	input  logic [bsc_pkg::FIELD_W-1:0]        alloc_b,
	input  logic [bsc_pkg::FIELD_W-1:0]        alloc_c,
	input  logic [bsc_pkg::FIELD_W-1:0]        max_a,
	input  logic [bsc_pkg::FIELD_W-1:0]        max_b,
	input  logic [bsc_pkg::FIELD_W-1:0]        max_c,
	input  logic                               last_proc,
	output logic                               res_valid,
	output logic [bsc_pkg::IDX_W-1:0]          proc_index,
	output logic [bsc_pkg::STAT_W-1:0]         check_status,
	output logic                               last_result
);

	localparam int NRES = bsc_pkg::NRES;
	localparam int RW   = RES_WIDTH;
	localparam int IW   = (RW < bsc_pkg::FIELD_W) ? RW : bsc_pkg::FIELD_W;
	localparam int ROWS = (MAX_PROCS + LANES - 1) / LANES;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW   = $clog2(MAX_PROCS + 1);
	localparam int SW   = RW + CW;
	localparam int XW   = $clog2(ROWS * LANES + 1);
	localparam int SLW  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int OW   = $clog2(LANES + 1);
	localparam int VW   = NRES * RW;

	bsc_pkg::state_t   state_q;
	logic [RW-1:0]     total_q   [NRES];
	logic [SW-1:0]     sum_q     [NRES];
	logic [RW-1:0]     avail_q   [NRES];
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     granted_q;
	logic [RAW-1:0]    wr_row_q;
	logic [SLW-1:0]    wr_lane_q;
	logic [RAW-1:0]    row_q;
	logic [OW-1:0]     off_q;
	logic              invalid_q;
	logic              progress_q;

	logic                    res_valid_q;
	logic [bsc_pkg::IDX_W-1:0]  proc_index_q;
	logic [bsc_pkg::STAT_W-1:0] check_status_q;
	logic                    last_result_q;

	logic [RW-1:0]     in_a [NRES];
	logic [RW-1:0]     in_m [NRES];
	logic [RW-1:0]     in_n [NRES];
	logic [NRES-1:0]   bad;
	logic [VW-1:0]     wr_alloc_flat;
	logic [VW-1:0]     wr_need_flat;
	logic [VW-1:0]     avail_flat;
	logic              accept;
	logic              full;
	logic              over;
	logic              run_inv;
	logic              row_end;
	logic              last_grant;
	logic              run_end;
	logic [XW-1:0]     grant_idx;
	logic              cfg_wr;
	logic [1:0]        cfg_idx;

	logic [LANES-1:0]        cand;
	logic [LANES*VW-1:0]     alloc_all;
	logic                    hit;
	logic [SLW-1:0]          sel;
	logic [VW-1:0]           sel_alloc;
	bsc_pkg::lane_ctl_t      lane_ctl [LANES];

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NRES; r++) begin
				total_q[r] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bsc_pkg::REG_TOTAL_A: total_q[0] <= pwdata[RW-1:0];
				bsc_pkg::REG_TOTAL_B: total_q[1] <= pwdata[RW-1:0];
				bsc_pkg::REG_TOTAL_C: total_q[2] <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			bsc_pkg::REG_TOTAL_A: prdata = bsc_pkg::DATA_W'(total_q[0]);
			bsc_pkg::REG_TOTAL_B: prdata = bsc_pkg::DATA_W'(total_q[1]);
			bsc_pkg::REG_TOTAL_C: prdata = bsc_pkg::DATA_W'(total_q[2]);
			default:              prdata = '0;
		endcase
	end

	// incoming process record
	assign in_a[0] = RW'(alloc_a[IW-1:0]);
	assign in_a[1] = RW'(alloc_b[IW-1:0]);
	assign in_a[2] = RW'(alloc_c[IW-1:0]);
	assign in_m[0] = RW'(max_a[IW-1:0]);
	assign in_m[1] = RW'(max_b[IW-1:0]);
	assign in_m[2] = RW'(max_c[IW-1:0]);

	always_comb begin
		run_inv = invalid_q;
		for (int r = 0; r < NRES; r++) begin
			bad[r]                  = in_a[r] > in_m[r];
			in_n[r]                 = bad[r] ? '0 : in_m[r] - in_a[r];
			wr_alloc_flat[r*RW +: RW] = in_a[r];
			wr_need_flat[r*RW +: RW]  = in_n[r];
			avail_flat[r*RW +: RW]    = avail_q[r];
			if (sum_q[r] > SW'(total_q[r])) begin
				run_inv = 1'b1;
			end
		end
	end

	assign busy       = (state_q != bsc_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign full       = (cnt_q == CW'(MAX_PROCS));
	assign row_end    = ((XW'(row_q) + XW'(1)) * XW'(LANES)) >= XW'(cnt_q);
	assign last_grant = ((granted_q + CW'(1)) == cnt_q);
	assign grant_idx  = XW'(row_q) * XW'(LANES) + XW'(sel);
	assign over       = (state_q == bsc_pkg::ST_EVAL) && !hit && row_end && !progress_q;
	assign run_end    = ((state_q == bsc_pkg::ST_PREP) && run_inv)
		|| ((state_q == bsc_pkg::ST_EVAL) && hit && last_grant)
		|| over;

	// lanes
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_comb begin
			lane_ctl[l].wr_en = accept && !full && (wr_lane_q == SLW'(l));
			lane_ctl[l].grant = (state_q == bsc_pkg::ST_EVAL) && hit && (sel == SLW'(l));
			lane_ctl[l].clr   = run_end;
		end

		bsc_lane #(
			.LANE_ID   (l),
			.LANES     (LANES),
			.MAX_PROCS (MAX_PROCS),
			.RES_WIDTH (RES_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl[l]),
			.wr_row   (wr_row_q),
			.wr_alloc (wr_alloc_flat),
			.wr_need  (wr_need_flat),
			.rd_row   (row_q),
			.proc_cnt (cnt_q),
			.avail    (avail_flat),
			.cand     (cand[l]),
			.alloc    (alloc_all[l*VW +: VW])
		);
	end

	bsc_pick #(
		.LANES     (LANES),
		.RES_WIDTH (RES_WIDTH)
	) u_pick (
		.cand      (cand),
		.off       (off_q),
		.alloc_all (alloc_all),
		.hit       (hit),
		.sel       (sel),
		.sel_alloc (sel_alloc)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bsc_pkg::ST_IDLE;
			cnt_q          <= '0;
			granted_q      <= '0;
			wr_row_q       <= '0;
			wr_lane_q      <= '0;
			row_q          <= '0;
			off_q          <= '0;
			invalid_q      <= 1'b0;
			progress_q     <= 1'b0;
			res_valid_q    <= 1'b0;
			proc_index_q   <= '0;
			check_status_q <= bsc_pkg::STAT_OK;
			last_result_q  <= 1'b0;
			for (int r = 0; r < NRES; r++) begin
				sum_q[r]   <= '0;
				avail_q[r] <= '0;
			end
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				bsc_pkg::ST_IDLE: begin
					if (accept) begin
						if (!full) begin
							cnt_q <= cnt_q + CW'(1);
							if (wr_lane_q == SLW'(LANES - 1)) begin
								wr_lane_q <= '0;
								wr_row_q  <= wr_row_q + RAW'(1);
							end else begin
								wr_lane_q <= wr_lane_q + SLW'(1);
							end
							for (int r = 0; r < NRES; r++) begin
								sum_q[r] <= sum_q[r] + SW'(in_a[r]);
							end
							if (|bad) begin
								invalid_q <= 1'b1;
							end
						end else begin
							invalid_q <= 1'b1;
						end
						if (last_proc) begin
							state_q <= bsc_pkg::ST_PREP;
						end
					end
				end
				bsc_pkg::ST_PREP: begin
					if (run_inv) begin
						res_valid_q    <= 1'b1;
						proc_index_q   <= '0;
						check_status_q <= bsc_pkg::STAT_INVALID;
						last_result_q  <= 1'b1;
						state_q        <= bsc_pkg::ST_IDLE;
					end else begin
						for (int r = 0; r < NRES; r++) begin
							avail_q[r] <= total_q[r] - sum_q[r][RW-1:0];
						end
						row_q      <= '0;
						off_q      <= '0;
						granted_q  <= '0;
						progress_q <= 1'b0;
						state_q    <= bsc_pkg::ST_FETCH;
					end
				end
				bsc_pkg::ST_FETCH: begin
					state_q <= bsc_pkg::ST_EVAL;
				end
				bsc_pkg::ST_EVAL: begin
					priority if (hit) begin
						for (int r = 0; r < NRES; r++) begin
							avail_q[r] <= avail_q[r] + sel_alloc[r*RW +: RW];
						end
						res_valid_q    <= 1'b1;
						proc_index_q   <= bsc_pkg::IDX_W'(grant_idx);
						check_status_q <= bsc_pkg::STAT_OK;
						last_result_q  <= last_grant;
						granted_q      <= granted_q + CW'(1);
						progress_q     <= 1'b1;
						off_q          <= OW'(sel) + OW'(1);
						if (last_grant) begin
							state_q <= bsc_pkg::ST_IDLE;
						end
					end else if (row_end) begin
						if (!progress_q) begin
							res_valid_q    <= 1'b1;
							proc_index_q   <= '0;
							check_status_q <= bsc_pkg::STAT_UNSAFE;
							last_result_q  <= 1'b1;
							state_q        <= bsc_pkg::ST_IDLE;
						end else begin
							progress_q <= 1'b0;
							row_q      <= '0;
							off_q      <= '0;
							state_q    <= bsc_pkg::ST_FETCH;
						end
					end else begin
						row_q   <= row_q + RAW'(1);
						off_q   <= '0;
						state_q <= bsc_pkg::ST_FETCH;
					end
				end
				default: begin
					state_q <= bsc_pkg::ST_IDLE;
				end
			endcase
			// end of run: drop the process set
			if (run_end) begin
				cnt_q     <= '0;
				wr_row_q  <= '0;
				wr_lane_q <= '0;
				invalid_q <= 1'b0;
				for (int r = 0; r < NRES; r++) begin
					sum_q[r] <= '0;
				end
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign proc_index   = proc_index_q;
	assign check_status = check_status_q;
	assign last_result  = last_result_q;

endmodule
